@@ src/assert_macros.svh @@
// Assertion helper macros for the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Implication checked at every clock edge outside reset
`define ASSERT_IMPL(label, clk, rst_n, a, c) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
        else $error("assertion failed");
// Next-cycle implication
`define ASSERT_NEXT(label, clk, rst_n, a, c) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
        else $error("assertion failed");
`endif

@@ src/avpc_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// avpc_pkg
// Shared constants and types of the access vector permission checker.
// ----------------------------------------------------------------------------
package avpc_pkg;
    localparam int RULE_DEPTH_DEF  = 64;
    localparam int CACHE_SLOTS_DEF = 16;
    localparam int ID_COUNT_DEF    = 256;

    localparam logic [1:0] CMD_INSERT = 2'd0;
    localparam logic [1:0] CMD_CHECK  = 2'd1;
    localparam logic [1:0] CMD_FLUSH  = 2'd2;
    localparam logic [1:0] CMD_UNUSED = 2'd3;

    localparam logic [1:0] REG_ENFORCING = 2'd0;
    localparam logic [1:0] REG_POLICY_SEQ = 2'd1;
    localparam logic [1:0] REG_LOWEST_ID = 2'd2;

    typedef struct packed {
        logic [47:0] key;
        logic [31:0] allow;
        logic [31:0] auditallow;
        logic [31:0] auditdeny;
        logic [31:0] seq;
    } entry_t;

    // Search token passed from cell to cell
    typedef struct packed {
        logic        busy;
        logic        found;
        logic        free;   // a free slot has been seen
        logic [47:0] key;
        entry_t      data;
    } token_t;

    typedef enum logic [3:0] {
        ST_IDLE  = 4'b0001,
        ST_CACHE = 4'b0010,
        ST_RULE  = 4'b0100,
        ST_OUT   = 4'b1000
    } state_t;
endpackage

@@ src/avpc_cell.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// avpc_cell
// One store entry: holds a key and vectors, matches the passing token.
// ----------------------------------------------------------------------------
module avpc_cell (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 clear,
    input  logic                 wr,
    input  avpc_pkg::entry_t     wr_data,
    input  avpc_pkg::token_t     tok_in,
    output avpc_pkg::token_t     tok_out,
    output logic                 valid
);
    avpc_pkg::entry_t ent_reg;
    logic             valid_reg;
    avpc_pkg::token_t tok_reg;
    avpc_pkg::token_t tok_next;

    always_comb
    begin
        tok_next = tok_in;
        if (tok_in.busy && !tok_in.found && valid_reg && ent_reg.key == tok_in.key)
        begin
            tok_next.found = 1'b1;
            tok_next.data  = ent_reg;
        end
        if (!valid_reg)
            tok_next.free = 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg    <= 1'b0;
            tok_reg.busy <= 1'b0;
        end
        else
        begin
            tok_reg <= tok_next;
            if (clear)
                valid_reg <= 1'b0;
            else if (wr)
                valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr)
            ent_reg <= wr_data;
    end

    assign tok_out = tok_reg;
    assign valid   = valid_reg;
endmodule

@@ src/avpc_chain.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// avpc_chain
// Row of entry cells; a search token walks one cell per cycle.
// ----------------------------------------------------------------------------
module avpc_chain #(
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     clear,
    input  logic [DEPTH-1:0]         wr,
    input  avpc_pkg::entry_t         wr_data,
    input  avpc_pkg::token_t         tok_in,
    output avpc_pkg::token_t         tok_out,
    output logic [DEPTH-1:0]         valid
);
    avpc_pkg::token_t tok [DEPTH+1];

    assign tok[0] = tok_in;

    for (genvar i = 0; i < DEPTH; i++)
    begin : g_cell
        avpc_cell u_cell (
            .clk     (clk),
            .rst_n   (rst_n),
            .clear   (clear),
            .wr      (wr[i]),
            .wr_data (wr_data),
            .tok_in  (tok[i]),
            .tok_out (tok[i+1]),
            .valid   (valid[i])
        );
    end

    assign tok_out = tok[DEPTH];
endmodule

@@ src/access_vector_permission_check.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// access_vector_permission_check
// Policy rule table with a decision cache, both built as rows of cells.
// ----------------------------------------------------------------------------
// One item at a time. Insert, flush and the unused command pass through the
// ST_OUT state into the output register. A check sends a search token down
// the cache row, one cell per cycle, and a hit is registered as it leaves the
// row; on a miss the token then walks the rule row, and the miss is registered
// as it leaves that row. The result waits in an output register and blocks the
// input; the next item is taken the cycle after the result is taken. No reset
// clearing pass.
module access_vector_permission_check #(
    parameter int RULE_DEPTH  = avpc_pkg::RULE_DEPTH_DEF,
    parameter int CACHE_SLOTS = avpc_pkg::CACHE_SLOTS_DEF,
    parameter int ID_COUNT    = avpc_pkg::ID_COUNT_DEF
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    // tdata: source_id, target_id, object_class, requested_bits,
    // rule_allow_bits, rule_auditallow_bits, rule_auditdeny_bits
    input  logic [175:0] s_tdata,
    // tuser: cmd
    input  logic [1:0]   s_tuser,
    output logic         m_tvalid,
    input  logic         m_tready,
    // tdata: granted, cache_hit, decided, allowed_vector, auditallow_vector,
    // auditdeny_vector, decision_sequence, rule_stored, zero fill
    output logic [135:0] m_tdata,
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic [1:0]   cfg_index,
    input  logic [31:0]  cfg_data
);
    localparam int RW = $clog2(RULE_DEPTH + 1);

    avpc_pkg::state_t state_reg, state_next;
    logic             enforcing_reg;
    logic [31:0]      policy_seq_reg;
    logic [15:0]      lowest_id_reg;
    logic [RW-1:0]    rule_count_reg;
    logic [1:0]       cmd_reg;
    logic [47:0]      key_reg;
    logic [31:0]      req_reg;
    avpc_pkg::entry_t rule_in_reg;
    logic             out_valid_reg;
    logic [135:0]     out_data_reg;

    avpc_pkg::token_t ctok_in, ctok_out, rtok_in, rtok_out;
    logic [CACHE_SLOTS-1:0] cache_wr, cache_valid;
    logic [RULE_DEPTH-1:0]  rule_wr, rule_valid;
    logic             rule_full;
    logic             cache_clear;
    avpc_pkg::entry_t cache_wdata;
    logic             range_bad;
    logic             miss_decided;
    avpc_pkg::entry_t miss_data;
    logic             do_check_done, do_miss_done, do_simple;
    logic [135:0]     result;

    assign cfg_ready = 1'b1;
    assign s_tready  = (state_reg == avpc_pkg::ST_IDLE) && !out_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            enforcing_reg  <= 1'b1;
            policy_seq_reg <= '0;
            lowest_id_reg  <= 16'd1;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                avpc_pkg::REG_ENFORCING:  enforcing_reg  <= cfg_data[0];
                avpc_pkg::REG_POLICY_SEQ: policy_seq_reg <= cfg_data;
                avpc_pkg::REG_LOWEST_ID:  lowest_id_reg  <= cfg_data[15:0];
                default: ;
            endcase
        end
    end

    wire accept = s_tvalid && s_tready;

    always_comb
    begin
        ctok_in      = '0;
        ctok_in.busy = accept && (s_tuser == avpc_pkg::CMD_CHECK);
        ctok_in.key  = s_tdata[47:0];
    end
    always_comb
    begin
        rtok_in      = '0;
        rtok_in.busy = (state_reg == avpc_pkg::ST_CACHE) && ctok_out.busy
                       && !ctok_out.found;
        rtok_in.key  = key_reg;
    end

    // keys are packed class:target:source, source in the low bits
    assign range_bad = key_reg[15:0] < lowest_id_reg || 32'(key_reg[15:0]) >= ID_COUNT
                    || key_reg[31:16] < lowest_id_reg || 32'(key_reg[31:16]) >= ID_COUNT;

    always_comb
    begin
        miss_data     = '0;
        miss_data.key = key_reg;
        miss_decided  = 1'b1;
        if (!range_bad)
        begin
            miss_decided = rtok_out.found;
            if (rtok_out.found)
            begin
                miss_data.allow      = rtok_out.data.allow;
                miss_data.auditallow = rtok_out.data.auditallow;
                miss_data.auditdeny  = rtok_out.data.auditdeny;
                miss_data.seq        = policy_seq_reg;
            end
        end
    end

    assign do_check_done = (state_reg == avpc_pkg::ST_CACHE) && ctok_out.busy
                           && ctok_out.found;
    assign do_miss_done  = (state_reg == avpc_pkg::ST_RULE) && rtok_out.busy;
    assign do_simple     = state_reg == avpc_pkg::ST_OUT;

    // first free cache slot, lowest index wins
    always_comb
    begin
        cache_wr = '0;
        for (int i = CACHE_SLOTS - 1; i >= 0; i--)
            if (!cache_valid[i])
            begin
                cache_wr    = '0;
                cache_wr[i] = do_miss_done;
            end
    end
    assign cache_wdata = miss_data;
    assign cache_clear = do_simple && cmd_reg == avpc_pkg::CMD_FLUSH;

    // rules fill in order, so the last cell marks a full table
    assign rule_full = rule_valid[RULE_DEPTH-1];

    always_comb
    begin
        rule_wr = '0;
        if (do_simple && cmd_reg == avpc_pkg::CMD_INSERT && !rule_full)
            rule_wr[rule_count_reg[$clog2(RULE_DEPTH > 1 ? RULE_DEPTH : 2)-1:0]] = 1'b1;
    end

    avpc_chain #(.DEPTH(CACHE_SLOTS)) u_cache (
        .clk (clk), .rst_n (rst_n), .clear (cache_clear), .wr (cache_wr),
        .wr_data (cache_wdata), .tok_in (ctok_in), .tok_out (ctok_out),
        .valid (cache_valid)
    );
    avpc_chain #(.DEPTH(RULE_DEPTH)) u_rule (
        .clk (clk), .rst_n (rst_n), .clear (1'b0), .wr (rule_wr),
        .wr_data (rule_in_reg), .tok_in (rtok_in), .tok_out (rtok_out),
        .valid (rule_valid)
    );

    always_comb
    begin
        result = '0;
        if (do_check_done)
        begin
            result[0] = ((ctok_out.data.allow & req_reg) == req_reg) || !enforcing_reg;
            result[1] = 1'b1;
            result[2] = 1'b1;
            result[34:3]    = ctok_out.data.allow;
            result[66:35]   = ctok_out.data.auditallow;
            result[98:67]   = ctok_out.data.auditdeny;
            result[130:99]  = ctok_out.data.seq;
        end
        else if (do_miss_done)
        begin
            result[0] = ((miss_data.allow & req_reg) == req_reg) || !enforcing_reg;
            result[2] = miss_decided;
            result[34:3]    = miss_data.allow;
            result[66:35]   = miss_data.auditallow;
            result[98:67]   = miss_data.auditdeny;
            result[130:99]  = miss_data.seq;
        end
        else
            result[131] = cmd_reg == avpc_pkg::CMD_INSERT && !rule_full;
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            avpc_pkg::ST_IDLE:
                if (accept)
                    state_next = (s_tuser == avpc_pkg::CMD_CHECK) ? avpc_pkg::ST_CACHE
                                                                  : avpc_pkg::ST_OUT;
            avpc_pkg::ST_CACHE:
                if (do_check_done)
                    state_next = avpc_pkg::ST_IDLE;
                else if (rtok_in.busy)
                    state_next = avpc_pkg::ST_RULE;
            avpc_pkg::ST_RULE:
                if (do_miss_done)
                    state_next = avpc_pkg::ST_IDLE;
            avpc_pkg::ST_OUT:
                state_next = avpc_pkg::ST_IDLE;
            default:
                state_next = avpc_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= avpc_pkg::ST_IDLE;
            rule_count_reg <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (|rule_wr)
                rule_count_reg <= rule_count_reg + 1'b1;
            if (do_check_done || do_miss_done || do_simple)
                out_valid_reg <= 1'b1;
            else if (m_tready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cmd_reg                <= s_tuser;
            key_reg                <= s_tdata[47:0];
            req_reg                <= s_tdata[79:48];
            rule_in_reg.key        <= s_tdata[47:0];
            rule_in_reg.allow      <= s_tdata[111:80];
            rule_in_reg.auditallow <= s_tdata[143:112];
            rule_in_reg.auditdeny  <= s_tdata[175:144];
            rule_in_reg.seq        <= '0;
        end
        if (do_check_done || do_miss_done || do_simple)
            out_data_reg <= result;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
endmodule

@@ src/avpc_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// avpc_checker
// Port-level checks of the permission checker, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"
module avpc_checker (
    input logic         clk,
    input logic         rst_n,
    input logic         s_tvalid,
    input logic         s_tready,
    input logic [1:0]   s_tuser,
    input logic         m_tvalid,
    input logic         m_tready,
    input logic [135:0] m_tdata
);
    // one item at a time: no new item while a result waits
    `ASSERT_IMPL(a_no_accept_pending, clk, rst_n, m_tvalid, !s_tready)
    // a result holds until taken
    `ASSERT_NEXT(a_out_hold, clk, rst_n, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))
    // a cache hit is always decided
    `ASSERT_IMPL(a_hit_decided, clk, rst_n, m_tvalid && m_tdata[1], m_tdata[2])
    // anything but a check shows its result after passing through the ST_OUT state
    `ASSERT_NEXT(a_simple_lat, clk, rst_n,
        s_tvalid && s_tready && s_tuser != avpc_pkg::CMD_CHECK, ##0 1'b1 ##1 m_tvalid)
endmodule

bind access_vector_permission_check avpc_checker u_avpc_checker (
    .clk (clk), .rst_n (rst_n), .s_tvalid (s_tvalid), .s_tready (s_tready),
    .s_tuser (s_tuser), .m_tvalid (m_tvalid), .m_tready (m_tready), .m_tdata (m_tdata)
);
